FILE: src/dtc_pkg.sv
// Shared constants, codes and types of the decision tree classifier.
`timescale 1ns / 1ps
package dtc_pkg;

  localparam int NODE_COUNT    = 256;
  localparam int FEATURE_COUNT = 32;
  localparam int MAX_DEPTH     = 16;
  localparam int VALUE_WIDTH   = 16;

  localparam int NODE_AW  = $clog2(NODE_COUNT);
  localparam int FEAT_AW  = $clog2(FEATURE_COUNT);
  localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [1:0] ACT_NODE_WR  = 2'd0;
  localparam logic [1:0] ACT_FEAT_WR  = 2'd1;
  localparam logic [1:0] ACT_CLASSIFY = 2'd2;

  // register index within the APB map
  localparam logic REG_ROOT_NODE = 1'b0;

  typedef struct packed {
    logic                          leaf;
    logic [4:0]                    feature;
    logic signed [VALUE_WIDTH-1:0] threshold;
    logic [7:0]                    left;
    logic [7:0]                    right;
    logic [7:0]                    label;
  } node_t;

  localparam int NODE_W = $bits(node_t);

endpackage

FILE: src/dtc_in_if.sv
// Input word channel of the decision tree classifier.
`timescale 1ns / 1ps
interface dtc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             action;
  logic [7:0]                             index;
  logic signed [dtc_pkg::VALUE_WIDTH-1:0] value;
  logic                                   leaf_flag;
  logic [4:0]                             split_feature;
  logic [7:0]                             left_child;
  logic [7:0]                             right_child;
  logic [7:0]                             leaf_label;

  modport source (
    output valid, action, index, value, leaf_flag, split_feature, left_child,
           right_child, leaf_label,
    input  ready
  );
  modport sink (
    input  valid, action, index, value, leaf_flag, split_feature, left_child,
           right_child, leaf_label,
    output ready
  );
endinterface

FILE: src/dtc_out_if.sv
// Result word channel of the decision tree classifier.
`timescale 1ns / 1ps
interface dtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] class_label;
  logic       walk_error;

  modport source (output valid, class_label, walk_error, input ready);
  modport sink (input valid, class_label, walk_error, output ready);
endinterface

FILE: src/dtc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/decision_tree_classifier.sv
// Decision tree classifier top level: node table, feature registers and tree walker.
`timescale 1ns / 1ps
// Node and feature writes take effect as their word is accepted. A classify walks the tree one
// level per cycle through the single read port of the node table RAM, comparing the selected
// feature against the node threshold in the same cycle: the root is read on acceptance, at most
// MAX_DEPTH node reads, root included, lead to the leaf, and the result then waits in ST_DONE.
// Input is not taken while a classify is in progress; the result sits in an output register so
// writes can be accepted while it waits. Node and feature entries must be written before a
// classify reads them. root_node sits at APB address 0.
module decision_tree_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dtc_in_if.sink                        in_i,
  dtc_out_if.source                     out_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [dtc_pkg::PADDR_W-1:0]   paddr_i,
  input  logic [dtc_pkg::PDATA_W-1:0]   pwdata_i,
  output logic [dtc_pkg::PDATA_W-1:0]   prdata_o,
  output logic                          pready_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                            state_q, state_d;
  logic [dtc_pkg::DEPTH_W-1:0]           depth_q, depth_d;
  logic [7:0]                            root_q;
  logic                                  out_valid_q, out_valid_d;
  logic [7:0]                            out_label_q, out_label_d;
  logic                                  out_err_q, out_err_d;
  logic [7:0]                            pend_label_q, pend_label_d;
  logic                                  pend_err_q, pend_err_d;
  logic signed [dtc_pkg::VALUE_WIDTH-1:0] feat_q [dtc_pkg::FEATURE_COUNT];

  logic                                  accept;
  logic                                  node_we;
  logic                                  node_re;
  logic [dtc_pkg::NODE_AW-1:0]           node_raddr;
  dtc_pkg::node_t                        node_wr;
  dtc_pkg::node_t                        node_rd;
  logic [dtc_pkg::NODE_W-1:0]            node_rdata;
  logic signed [dtc_pkg::VALUE_WIDTH-1:0] feat_sel;
  logic [7:0]                            next_node;
  logic                                  last_step;
  logic                                  out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // APB
  assign pready_o = 1'b1;
  assign prdata_o = {{(dtc_pkg::PDATA_W-8){1'b0}}, root_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= 8'd0;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 paddr_i[2] == dtc_pkg::REG_ROOT_NODE) begin
      root_q <= pwdata_i[7:0];
    end
  end

  // node table
  assign node_wr.leaf      = in_i.leaf_flag;
  assign node_wr.feature   = in_i.split_feature;
  assign node_wr.threshold = in_i.value;
  assign node_wr.left      = in_i.left_child;
  assign node_wr.right     = in_i.right_child;
  assign node_wr.label     = in_i.leaf_label;

  assign node_we = accept && (in_i.action == dtc_pkg::ACT_NODE_WR);

  dtc_ram #(
    .WIDTH (dtc_pkg::NODE_W),
    .DEPTH (dtc_pkg::NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (in_i.index[dtc_pkg::NODE_AW-1:0]),
    .wdata_i (node_wr),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  assign node_rd = dtc_pkg::node_t'(node_rdata);

  // feature registers
  always_ff @(posedge clk_i) begin
    if (accept && in_i.action == dtc_pkg::ACT_FEAT_WR) begin
      feat_q[in_i.index[dtc_pkg::FEAT_AW-1:0]] <= in_i.value;
    end
  end

  assign feat_sel  = feat_q[node_rd.feature[dtc_pkg::FEAT_AW-1:0]];
  assign next_node = (feat_sel < node_rd.threshold) ? node_rd.left : node_rd.right;
  assign last_step = (depth_q == dtc_pkg::DEPTH_W'(dtc_pkg::MAX_DEPTH - 1));
  assign out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    state_d      = state_q;
    depth_d      = depth_q;
    pend_label_d = pend_label_q;
    pend_err_d   = pend_err_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_label_d  = out_label_q;
    out_err_d    = out_err_q;
    node_re      = 1'b0;
    node_raddr   = root_q[dtc_pkg::NODE_AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (accept && in_i.action == dtc_pkg::ACT_CLASSIFY) begin
          node_re = 1'b1;
          depth_d = '0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (node_rd.leaf) begin
          pend_label_d = node_rd.label;
          pend_err_d   = 1'b0;
          state_d      = ST_DONE;
        end else if (last_step) begin
          pend_label_d = 8'd0;
          pend_err_d   = 1'b1;
          state_d      = ST_DONE;
        end else begin
          node_re    = 1'b1;
          node_raddr = next_node[dtc_pkg::NODE_AW-1:0];
          depth_d    = depth_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_label_d = pend_label_q;
          out_err_d   = pend_err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_label_q <= pend_label_d;
    pend_err_q   <= pend_err_d;
    out_label_q  <= out_label_d;
    out_err_q    <= out_err_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.class_label = out_label_q;
  assign out_o.walk_error  = out_err_q;

endmodule

FILE: src/dtc_checker.sv
// Port-level assertions for the decision tree classifier, bound to the top level.
`timescale 1ns / 1ps
module dtc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [1:0]                  in_action_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [7:0]                  out_label_i,
  input logic                        out_err_i,
  input logic                        psel_i,
  input logic                        penable_i,
  input logic                        pwrite_i,
  input logic [dtc_pkg::PADDR_W-1:0] paddr_i,
  input logic [dtc_pkg::PDATA_W-1:0] pwdata_i,
  input logic [dtc_pkg::PDATA_W-1:0] prdata_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before it was taken");

  a_err_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_err_i |-> out_label_i == 8'd0)
    else $error("walk error with non-zero label");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i == dtc_pkg::ACT_CLASSIFY |=> !in_ready_i)
    else $error("input taken during a tree walk");

  a_root_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && paddr_i[2] == dtc_pkg::REG_ROOT_NODE
    |=> prdata_i == {{(dtc_pkg::PDATA_W-8){1'b0}}, $past(pwdata_i[7:0])})
    else $error("root_node readback mismatch");

endmodule

bind decision_tree_classifier dtc_checker u_dtc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_label_i (out_o.class_label),
  .out_err_i   (out_o.walk_error),
  .psel_i      (psel_i),
  .penable_i   (penable_i),
  .pwrite_i    (pwrite_i),
  .paddr_i     (paddr_i),
  .pwdata_i    (pwdata_i),
  .prdata_i    (prdata_o)
);

FILE: sim/decision_tree_classifier_tb.sv
// Self-checking testbench of the decision tree classifier against a label predictor.
`timescale 1ns / 1ps
module decision_tree_classifier_tb;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [dtc_pkg::PADDR_W-1:0] ROOT_ADDR =
    dtc_pkg::PADDR_W'(4 * dtc_pkg::REG_ROOT_NODE);

  typedef struct packed {
    logic [1:0]                             action;
    logic [7:0]                             index;
    logic signed [dtc_pkg::VALUE_WIDTH-1:0] value;
    logic                                   leaf_flag;
    logic [4:0]                             split_feature;
    logic [7:0]                             left_child;
    logic [7:0]                             right_child;
    logic [7:0]                             leaf_label;
  } tree_word_t;

  typedef struct packed {
    logic [7:0] label;
    logic       err;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [dtc_pkg::PADDR_W-1:0] paddr;
  logic [dtc_pkg::PDATA_W-1:0] pwdata;
  logic [dtc_pkg::PDATA_W-1:0] prdata;
  logic pready;

  dtc_in_if  in_ch ();
  dtc_out_if res_ch ();

  decision_tree_classifier dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_ch),
    .out_o     (res_ch),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  // predictor state
  dtc_pkg::node_t                         node_tbl [dtc_pkg::NODE_COUNT];
  logic signed [dtc_pkg::VALUE_WIDTH-1:0] feat_vals [dtc_pkg::FEATURE_COUNT];
  logic [7:0]                             root_sel;
  verdict_t                               due_labels [$];

  // feature values as the queued words will leave them
  logic signed [dtc_pkg::VALUE_WIDTH-1:0] plan_feat [dtc_pkg::FEATURE_COUNT];

  tree_word_t word_q [$];
  tree_word_t next_word;
  int         words_made;
  int         mismatches;
  bit         idle_on;
  bit         word_taken;
  int         gap_left;
  int         stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void tree_step(input tree_word_t w);
    dtc_pkg::node_t n;
    verdict_t       v;
    logic [7:0]     cur;
    case (w.action)
      dtc_pkg::ACT_NODE_WR: begin
        n.leaf      = w.leaf_flag;
        n.feature   = w.split_feature;
        n.threshold = w.value;
        n.left      = w.left_child;
        n.right     = w.right_child;
        n.label     = w.leaf_label;
        node_tbl[w.index] = n;
      end
      dtc_pkg::ACT_FEAT_WR: feat_vals[w.index % dtc_pkg::FEATURE_COUNT] = w.value;
      dtc_pkg::ACT_CLASSIFY: begin
        cur   = root_sel;
        v.label = 8'd0;
        v.err   = 1'b1;
        for (int steps = 0; steps < dtc_pkg::MAX_DEPTH; steps++) begin
          n = node_tbl[cur];
          if (n.leaf) begin
            v.label = n.label;
            v.err   = 1'b0;
            break;
          end
          if ($signed(feat_vals[n.feature]) < $signed(n.threshold)) cur = n.left;
          else cur = n.right;
        end
        due_labels = {due_labels, v};
      end
      default: ;
    endcase
  endfunction

  // word acceptance
  always @(posedge clk) begin
    word_taken = rst_n && in_ch.valid && in_ch.ready;
    if (word_taken)
      tree_step({in_ch.action, in_ch.index, in_ch.value, in_ch.leaf_flag, in_ch.split_feature,
                 in_ch.left_child, in_ch.right_child, in_ch.leaf_label});
  end

  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || word_taken)) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left = gap_left - 1;
      end else if (word_q.size() != 0) begin
        next_word = word_q.pop_front();
        {in_ch.action, in_ch.index, in_ch.value, in_ch.leaf_flag, in_ch.split_feature,
         in_ch.left_child, in_ch.right_child, in_ch.leaf_label} <= next_word;
        in_ch.valid <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 15);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
    end
  end

  // result check
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (due_labels.size() == 0) begin
        $display("%0t: expected no word, got label %0d err %0b", $time, res_ch.class_label,
                 res_ch.walk_error);
        mismatches++;
      end else begin
        exp_v = due_labels.pop_front();
        if (res_ch.class_label !== exp_v.label) begin
          $display("%0t: class_label expected %0d got %0d", $time, exp_v.label,
                   res_ch.class_label);
          mismatches++;
        end
        if (res_ch.walk_error !== exp_v.err) begin
          $display("%0t: walk_error expected %0b got %0b", $time, exp_v.err,
                   res_ch.walk_error);
          mismatches++;
        end
      end
    end
  end

  function automatic logic signed [dtc_pkg::VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: case ($urandom_range(0, 4))
           0:       return 16'h8000;
           1:       return 16'hFFFF;
           2:       return 16'h0000;
           3:       return 16'h0001;
           default: return 16'h7FFF;
         endcase
      1:       return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_word(input logic [1:0] act, input logic [7:0] idx,
                          input logic signed [dtc_pkg::VALUE_WIDTH-1:0] val, input logic leaf,
                          input logic [4:0] feat, input logic [7:0] lc, input logic [7:0] rc,
                          input logic [7:0] lab);
    tree_word_t w;
    w = '{act, idx, val, leaf, feat, lc, rc, lab};
    word_q = {word_q, w};
    if (act != ACT_NONE) words_made++;
  endtask

  task automatic queue_feature(input logic [7:0] idx,
                               input logic signed [dtc_pkg::VALUE_WIDTH-1:0] val);
    plan_feat[idx % dtc_pkg::FEATURE_COUNT] = val;
    add_word(dtc_pkg::ACT_FEAT_WR, idx, val, 1'($urandom), 5'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom));
  endtask

  task automatic queue_classify();
    add_word(dtc_pkg::ACT_CLASSIFY, 8'($urandom), 16'($urandom), 1'($urandom), 5'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // path of distinct nodes from the root, leaf at its last node
  task automatic queue_chain(input int depth);
    logic [7:0]                             path [$];
    bit                                     on_path [dtc_pkg::NODE_COUNT];
    logic [7:0]                             nxt;
    logic [7:0]                             other;
    logic [4:0]                             f;
    logic signed [dtc_pkg::VALUE_WIDTH-1:0] thr;
    on_path = '{default: 1'b0};
    path = {path, root_sel};
    on_path[root_sel] = 1'b1;
    while (path.size() < depth) begin
      nxt = 8'($urandom);
      if (!on_path[nxt]) begin
        path = {path, nxt};
        on_path[nxt] = 1'b1;
      end
    end
    for (int k = 0; k < depth - 1; k++) begin
      f     = 5'($urandom);
      thr   = ($urandom_range(0, 3) == 0) ? plan_feat[f] : pick_value();
      other = 8'($urandom);
      if ($signed(plan_feat[f]) < $signed(thr))
        add_word(dtc_pkg::ACT_NODE_WR, path[k], thr, 1'b0, f, path[k+1], other, 8'($urandom));
      else
        add_word(dtc_pkg::ACT_NODE_WR, path[k], thr, 1'b0, f, other, path[k+1], 8'($urandom));
    end
    add_word(dtc_pkg::ACT_NODE_WR, path[depth-1], pick_value(), 1'b1, 5'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom));
    queue_classify();
  endtask

  task automatic queue_random(input int n);
    int stop;
    int pick;
    int depth;
    stop = words_made + n;
    while (words_made < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        depth = ($urandom_range(0, 2) == 0) ?
                $urandom_range(dtc_pkg::MAX_DEPTH - 2, dtc_pkg::MAX_DEPTH + 2) :
                $urandom_range(1, 10);
        queue_chain(depth);
        repeat ($urandom_range(0, 2)) begin
          queue_feature(8'($urandom), pick_value());
          queue_classify();
        end
      end else if (pick < 55) begin
        add_word(dtc_pkg::ACT_NODE_WR, 8'($urandom), pick_value(), $urandom_range(0, 7) == 0,
                 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 75) begin
        queue_feature(8'($urandom), pick_value());
      end else if (pick < 93) begin
        queue_classify();
      end else begin
        add_word(ACT_NONE, 8'($urandom), 16'($urandom), 1'($urandom), 5'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic set_root(input logic [7:0] v);
    logic [dtc_pkg::PDATA_W-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROOT_ADDR;
    pwdata  <= dtc_pkg::PDATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    root_sel = v;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== dtc_pkg::PDATA_W'(v)) begin
      $display("%0t: root_node readback expected %0d got %0d", $time, v, rd);
      mismatches++;
    end
  endtask

  // wait for the input side to drain and every label to arrive
  task automatic settle();
    while (word_q.size() != 0 || in_ch.valid || due_labels.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    {in_ch.valid, in_ch.action, in_ch.index, in_ch.value, in_ch.leaf_flag, in_ch.split_feature,
     in_ch.left_child, in_ch.right_child, in_ch.leaf_label} = '0;
    res_ch.ready = 1'b0;
    root_sel = 8'd0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    set_root(8'd0);

    // extremes, equal compare going right, index wrap, unused action, loop in the table
    queue_feature(8'd0, 16'h8000);
    queue_feature(8'd255, 16'h7FFF);
    queue_feature(8'd1, 16'h0100);
    add_word(dtc_pkg::ACT_NODE_WR, 8'd0, 16'h0100, 1'b0, 5'd1, 8'd1, 8'd2, 8'hAA);
    add_word(dtc_pkg::ACT_NODE_WR, 8'd2, 16'h7FFF, 1'b0, 5'd31, 8'd3, 8'd255, 8'd0);
    add_word(dtc_pkg::ACT_NODE_WR, 8'd255, 16'h8000, 1'b1, 5'd31, 8'd255, 8'd255, 8'd255);
    queue_classify();
    add_word(dtc_pkg::ACT_NODE_WR, 8'd1, 16'h0000, 1'b1, 5'd0, 8'd0, 8'd0, 8'd0);
    queue_feature(8'd33, 16'h00FF);
    queue_classify();
    add_word(ACT_NONE, 8'hFF, 16'hFFFF, 1'b1, 5'd31, 8'hFF, 8'hFF, 8'hFF);
    queue_feature(8'd1, 16'h0100);
    add_word(dtc_pkg::ACT_NODE_WR, 8'd2, 16'h8001, 1'b0, 5'd0, 8'd3, 8'd255, 8'd0);
    add_word(dtc_pkg::ACT_NODE_WR, 8'd3, 16'h8000, 1'b0, 5'd0, 8'd3, 8'd3, 8'hFF);
    queue_classify();
    add_word(dtc_pkg::ACT_NODE_WR, 8'd0, 16'h0000, 1'b1, 5'd0, 8'd0, 8'd0, 8'h5A);
    queue_classify();
    settle();

    // fill both tables so any walk stays on written entries
    for (int i = 0; i < dtc_pkg::FEATURE_COUNT; i++)
      queue_feature(8'(i + dtc_pkg::FEATURE_COUNT * $urandom_range(0, 7)), pick_value());
    for (int i = 0; i < dtc_pkg::NODE_COUNT; i++)
      add_word(dtc_pkg::ACT_NODE_WR, 8'(i), pick_value(), $urandom_range(0, 7) == 0,
               5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    queue_random(300);
    settle();

    set_root(8'd255);
    queue_random(200);
    settle();

    set_root(8'($urandom));
    queue_random(180);
    settle();

    set_root(8'($urandom));
    idle_on = 1'b0;
    queue_random(150);
    settle();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
